/* hdl/svtg_pkg.sv */
// Package for the six-voice tone generator: widths, codes, controller types,
// frequency and voice-pattern tables, and the controller-to-datapath command.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package svtg_pkg;

   localparam int VOICES   = 6;
   localparam int VOICE_W  = 3;
   localparam int PITCH_W  = 4;
   localparam int PHASE_W  = 20;
   localparam int FREQ_W   = 14;
   localparam int GAIN_W   = 8;
   localparam int DATA_W   = 8;
   localparam int SAMPLE_W = 8;
   localparam int CONTRIB_W = 13;
   localparam int SUM_W    = 15;
   localparam int PROD_W   = 24;
   localparam int MAG_W    = 23;
   localparam int ADDR_W   = 3;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd48;

   // Register index of mix_gain on the CSR port
   localparam logic REG_MIX_GAIN = 1'b0;

   // Item operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Saturation bound and divider limit: 128 * 96
   localparam logic [MAG_W-1:0] SAT_LIMIT = 23'd12288;
   localparam logic [6:0] SAT_VALUE = 7'd127;
   localparam logic [7:0] RECIP3 = 8'd171;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_SCALE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               load_write;
      logic               clear_sum;
      logic               step_voice;
      logic [VOICE_W-1:0] voice;
      logic               scale;
      logic               finish;
   } cmd_type;

   localparam logic [FREQ_W-1:0] FREQ_ROM [VOICES][16] = '{
      '{14'd0, 14'd987, 14'd1046, 14'd1108, 14'd1174, 14'd1244, 14'd1318, 14'd1396,
        14'd1479, 14'd1567, 14'd1661, 14'd1759, 14'd1864, 14'd1975, 14'd0, 14'd0},
      '{14'd0, 14'd1975, 14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2793,
        14'd2959, 14'd3135, 14'd3322, 14'd3519, 14'd3729, 14'd3951, 14'd0, 14'd0},
      '{14'd0, 14'd2637, 14'd2793, 14'd2959, 14'd3135, 14'd3322, 14'd3519, 14'd3729,
        14'd3951, 14'd4186, 14'd4434, 14'd4698, 14'd4978, 14'd5274, 14'd0, 14'd0},
      '{14'd0, 14'd3951, 14'd4186, 14'd4434, 14'd4698, 14'd4978, 14'd5274, 14'd5587,
        14'd5919, 14'd6271, 14'd6644, 14'd7039, 14'd7458, 14'd7902, 14'd0, 14'd0},
      '{14'd0, 14'd5274, 14'd5587, 14'd5919, 14'd6271, 14'd6644, 14'd7039, 14'd7458,
        14'd7902, 14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd0, 14'd0},
      '{14'd0, 14'd7902, 14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd11175,
        14'd11839, 14'd12543, 14'd13289, 14'd14079, 14'd14917, 14'd15804, 14'd0, 14'd0}
   };

   // Frequency word of one voice at one pitch; voices past the last read zero
   function automatic logic [FREQ_W-1:0] freq_word(input logic [VOICE_W-1:0] voice,
                                                   input logic [PITCH_W-1:0] pitch);
      logic [FREQ_W-1:0] word;
      word = '0;
      if (voice < VOICE_W'(VOICES)) begin
         word = FREQ_ROM[voice][pitch];
      end
      return word;
   endfunction

   // Voice enable pattern from the high nibble of a written byte
   function automatic logic [VOICES-1:0] voice_pattern(input logic [3:0] nib);
      logic [VOICES-1:0] pat;
      case (nib) inside
         4'h2:               pat = 6'b100100;
         4'h7, 4'hA:         pat = 6'b001000;
         4'h9, [4'hD:4'hF]:  pat = 6'b000000;
         default:            pat = 6'b100000;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

/* hdl/svtg_if.sv */
// Channel interfaces of the tone generator: request item and response item.
// Depends on svtg_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface svtg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [svtg_pkg::DATA_W-1:0]   data;

   modport source (output valid, output operation, output data, input ready);
   modport sink   (input valid, input operation, input data, output ready);
endinterface

interface svtg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [svtg_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* hdl/svtg_ctrl.sv */
// Controller of the tone generator: sequences write items and tick items,
// walks the voices and owns the response valid flag. Depends on svtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svtg_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_operation,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output svtg_pkg::cmd_type      cmd
);

   svtg_pkg::state_type state_ff, state_in;
   logic [svtg_pkg::VOICE_W-1:0] voice_ff, voice_in;
   logic rsp_valid_ff, rsp_valid_in;

   // State, voice counter and response flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svtg_pkg::ST_IDLE;
         voice_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         voice_ff     <= voice_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      voice_in       = voice_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.voice      = voice_ff;
      case (state_ff)
         svtg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == svtg_pkg::OP_TICK) begin
                  cmd.clear_sum = 1'b1;
                  voice_in      = '0;
                  state_in      = svtg_pkg::ST_ACCUM;
               end else begin
                  cmd.load_write = 1'b1;
               end
            end
         end
         svtg_pkg::ST_ACCUM: begin
            cmd.step_voice = 1'b1;
            voice_in       = voice_ff + 1'b1;
            if (voice_ff == svtg_pkg::VOICE_W'(svtg_pkg::VOICES - 1)) begin
               state_in = svtg_pkg::ST_SCALE;
            end
         end
         svtg_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = svtg_pkg::ST_FINISH;
         end
         svtg_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = svtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = svtg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/svtg_datapath.sv */
// Datapath of the tone generator: pitch and enable registers, six phase
// accumulators, voice sum, gain multiply, divide by 96 and saturation.
// Depends on svtg_pkg; driven by svtg_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module svtg_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire svtg_pkg::cmd_type                    cmd,
   input  wire logic [svtg_pkg::DATA_W-1:0]          req_data,
   input  wire logic [svtg_pkg::GAIN_W-1:0]          mix_gain,
   output logic signed [svtg_pkg::SAMPLE_W-1:0]      sample
);

   logic [svtg_pkg::PHASE_W-1:0] phase_ff [svtg_pkg::VOICES];
   logic [svtg_pkg::PHASE_W-1:0] phase_in;
   logic [svtg_pkg::VOICES-1:0]  enable_ff;
   logic [svtg_pkg::PITCH_W-1:0] pitch_ff;
   logic signed [svtg_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic signed [svtg_pkg::PROD_W-1:0] prod_ff;
   logic signed [svtg_pkg::SAMPLE_W-1:0] sample_ff, sample_in;

   logic [svtg_pkg::FREQ_W-1:0]      freq;
   logic                             active;
   logic signed [4:0]                diff;
   logic signed [svtg_pkg::CONTRIB_W-1:0] contrib;
   logic [svtg_pkg::PROD_W-1:0]      prod_abs;
   logic [svtg_pkg::MAG_W-1:0]       mag;
   logic [8:0]                       coarse;
   logic [16:0]                      recip;
   logic [6:0]                       quot;

   // Advance the selected voice and form its contribution
   always_comb begin
      freq     = svtg_pkg::freq_word(cmd.voice, pitch_ff);
      active   = enable_ff[cmd.voice] && (freq != '0);
      phase_in = phase_ff[cmd.voice] + {{(svtg_pkg::PHASE_W - svtg_pkg::FREQ_W){1'b0}}, freq};
      diff     = $signed({1'b0, phase_in[19:16]}) - 5'sd8;
      contrib  = ($signed({{8{diff[4]}}, diff}) <<< 8) - $signed({{8{diff[4]}}, diff});
      sum_in   = sum_ff;
      if (active) begin
         sum_in = sum_ff + $signed({{(svtg_pkg::SUM_W - svtg_pkg::CONTRIB_W){contrib[12]}},
                                    contrib});
      end
   end

   // Divide the magnitude by 96 as (x >> 5) / 3, saturate, restore sign
   always_comb begin
      prod_abs  = prod_ff[svtg_pkg::PROD_W-1] ? (~prod_ff + 1'b1) : prod_ff;
      mag       = prod_abs[svtg_pkg::MAG_W-1:0];
      coarse    = mag[13:5];
      recip     = coarse * svtg_pkg::RECIP3;
      quot      = recip[15:9];
      if (mag >= svtg_pkg::SAT_LIMIT) begin
         quot = svtg_pkg::SAT_VALUE;
      end
      sample_in = prod_ff[svtg_pkg::PROD_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   end

   // Control state: phases, enables, pitch
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < svtg_pkg::VOICES; v++) begin
            phase_ff[v] <= '0;
         end
         enable_ff <= '0;
         pitch_ff  <= '0;
      end else begin
         if (cmd.load_write) begin
            pitch_ff  <= req_data[3:0] + 1'b1;
            enable_ff <= svtg_pkg::voice_pattern(req_data[7:4]);
         end
         if (cmd.step_voice && active) begin
            phase_ff[cmd.voice] <= phase_in;
         end
      end
   end

   // Sum, product and sample registers
   always_ff @(posedge clock) begin
      if (cmd.clear_sum) begin
         sum_ff <= '0;
      end else if (cmd.step_voice) begin
         sum_ff <= sum_in;
      end
      if (cmd.scale) begin
         prod_ff <= svtg_pkg::PROD_W'(sum_ff * $signed({1'b0, mix_gain}));
      end
      if (cmd.finish) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

`default_nettype wire

/* hdl/six_voice_tone_generator.sv */
// Top level of the six-voice tone generator: CSR port with the mix gain
// register, controller and datapath. Depends on svtg_pkg, svtg_if, svtg_ctrl,
// svtg_datapath.
//
//   channel   direction  fields                 handshake
//   req_bus   in         operation[0], data[7:0] valid / ready
//   rsp_bus   out        sample[7:0] signed     valid / ready
//   csr_*     in/out     mix_gain at byte 0     APB, pready tied high
//
// A write item is taken straight from idle; a tick item walks the voices one by one
// through the shared phase adder, then a gain multiply state and a divide and
// saturate state into the output register, and only then is the next item taken.
// The output register holds a sample until it is taken; write items are taken
// meanwhile, and a finished tick waits only if the previous sample is still held.
// Reset clears phases, enables, pitch and the gain (to 48).
`timescale 1ns / 1ps
`default_nettype none

module six_voice_tone_generator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   svtg_req_if.sink                           req_bus,
   svtg_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [svtg_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic [svtg_pkg::GAIN_W-1:0] gain_ff, gain_in;
   svtg_pkg::cmd_type cmd;
   logic reg_sel;

   // Register file: one gain register, written on the access cycle
   assign reg_sel    = csr_paddr[2] == svtg_pkg::REG_MIX_GAIN;
   assign csr_pready = 1'b1;

   always_comb begin
      gain_in = gain_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         gain_in = csr_pwdata[svtg_pkg::GAIN_W-1:0];
      end
      csr_prdata = '0;
      if (reg_sel) begin
         csr_prdata = {{(32 - svtg_pkg::GAIN_W){1'b0}}, gain_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= svtg_pkg::GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   svtg_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .cmd           (cmd)
   );

   svtg_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_bus.data),
      .mix_gain (gain_ff),
      .sample   (rsp_bus.sample)
   );

endmodule

`default_nettype wire

/* verif/six_voice_tone_generator_test.sv */
// Testbench for six_voice_tone_generator: drives write and tick items, checks
// every sample against an in-bench model of the voices, and exercises the gain CSR.
// Depends on svtg_pkg, svtg_if and the six_voice_tone_generator RTL.
`timescale 1ns / 1ps

module six_voice_tone_generator_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int STALL_CYCLES   = 400;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [svtg_pkg::ADDR_W-1:0] MIX_GAIN_ADDR =
      svtg_pkg::ADDR_W'(4 * int'(svtg_pkg::REG_MIX_GAIN));
   localparam logic [svtg_pkg::ADDR_W-1:0] UNMAPPED_ADDR =
      svtg_pkg::ADDR_W'(4 * (int'(svtg_pkg::REG_MIX_GAIN) + 1));

   // Phase increments per voice and pitch
   localparam int unsigned TONE_FREQ [6][16] = '{
      '{0, 987, 1046, 1108, 1174, 1244, 1318, 1396,
        1479, 1567, 1661, 1759, 1864, 1975, 0, 0},
      '{0, 1975, 2093, 2217, 2349, 2489, 2637, 2793,
        2959, 3135, 3322, 3519, 3729, 3951, 0, 0},
      '{0, 2637, 2793, 2959, 3135, 3322, 3519, 3729,
        3951, 4186, 4434, 4698, 4978, 5274, 0, 0},
      '{0, 3951, 4186, 4434, 4698, 4978, 5274, 5587,
        5919, 6271, 6644, 7039, 7458, 7902, 0, 0},
      '{0, 5274, 5587, 5919, 6271, 6644, 7039, 7458,
        7902, 8372, 8869, 9397, 9956, 10548, 0, 0},
      '{0, 7902, 8372, 8869, 9397, 9956, 10548, 11175,
        11839, 12543, 13289, 14079, 14917, 15804, 0, 0}
   };

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [svtg_pkg::ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   svtg_req_if req_bus ();
   svtg_rsp_if rsp_bus ();

   six_voice_tone_generator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Tone model state
   logic [svtg_pkg::PHASE_W-1:0] tone_phase [svtg_pkg::VOICES];
   logic [svtg_pkg::VOICES-1:0]  tone_enable;
   logic [svtg_pkg::PITCH_W-1:0] tone_pitch;
   logic [svtg_pkg::GAIN_W-1:0]  tone_gain;

   logic signed [svtg_pkg::SAMPLE_W-1:0] expected_samples [$];
   int error_count;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_requests;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Update the tone model with one accepted item; queue the sample of a tick
   task automatic tone_model_step(input logic op, input logic [svtg_pkg::DATA_W-1:0] data);
      int sum;
      int scaled;
      int v;
      int unsigned freq;
      logic [3:0] nib;
      if (op == svtg_pkg::OP_WRITE) begin
         tone_pitch = data[3:0] + 4'd1;
         case (data[7:4])
            4'h2:                      tone_enable = 6'b100100;
            4'h7, 4'hA:                tone_enable = 6'b001000;
            4'h9, 4'hD, 4'hE, 4'hF:    tone_enable = 6'b000000;
            default:                   tone_enable = 6'b100000;
         endcase
      end else begin
         sum = 0;
         for (v = 0; v < svtg_pkg::VOICES; v++) begin
            freq = TONE_FREQ[v][tone_pitch];
            if (tone_enable[v] && freq != 0) begin
               tone_phase[v] = tone_phase[v] + svtg_pkg::PHASE_W'(freq);
               nib = tone_phase[v][19:16];
               sum += (int'(nib) - 8) * 255;
            end
         end
         scaled = (sum * int'(tone_gain)) / 96;
         if (scaled > 127) scaled = 127;
         if (scaled < -127) scaled = -127;
         expected_samples.push_back(svtg_pkg::SAMPLE_W'(scaled));
      end
   endtask

   // Offer one item after a random gap; hold it until accepted
   task automatic send_item(input logic op, input logic [svtg_pkg::DATA_W-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.data      <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tone_model_step(op, data);
   endtask

   // Drop valid and wait until every sample is in, then let the block settle
   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready
   task automatic csr_access(input logic wr, input logic [svtg_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Read the gain back and compare with the model
   task automatic check_gain_readback();
      logic [31:0] rdata;
      csr_access(1'b0, MIX_GAIN_ADDR, 32'd0, rdata);
      if (rdata !== 32'(tone_gain)) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("mix_gain readback: expected %0d, got %0h", tone_gain, rdata);
      end
   endtask

   // Write the gain while the block is idle; junk in the upper byte is ignored
   task automatic set_gain(input logic [svtg_pkg::GAIN_W-1:0] gain);
      logic [31:0] rdata;
      wait_for_results();
      csr_access(1'b1, MIX_GAIN_ADDR, {8'($urandom_range(255)), 16'h0000, gain}, rdata);
      tone_gain = gain;
      check_gain_readback();
   endtask

   // Random tone runs: a write then a burst of ticks, with some stray items
   task automatic run_random(input int count);
      int sent;
      int run_len;
      int i;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) begin
            send_item(svtg_pkg::OP_WRITE, svtg_pkg::DATA_W'($urandom_range(255)));
            run_len = $urandom_range(40, 1);
            for (i = 0; i < run_len; i++)
               send_item(svtg_pkg::OP_TICK, svtg_pkg::DATA_W'($urandom_range(255)));
            sent += run_len + 1;
         end else begin
            send_item(logic'($urandom_range(1)), svtg_pkg::DATA_W'($urandom_range(255)));
            sent++;
         end
      end
   endtask

   // Reset state: all voices off, gain 48
   task automatic test_reset_state();
      check_gain_readback();
      send_item(svtg_pkg::OP_TICK, 8'hFF);
   endtask

   // Voice patterns and the silent pitches at the default gain
   task automatic test_voice_patterns();
      logic [svtg_pkg::DATA_W-1:0] writes [10];
      int i;
      writes = '{8'h2C, 8'h70, 8'hA5, 8'h93, 8'hFF, 8'h0D, 8'h5E, 8'h1F, 8'h3B, 8'hE8};
      for (i = 0; i < 10; i++) begin
         send_item(svtg_pkg::OP_WRITE, writes[i]);
         send_item(svtg_pkg::OP_TICK, svtg_pkg::DATA_W'($urandom_range(255)));
      end
      send_item(svtg_pkg::OP_TICK, 8'h00);
   endtask

   // Gain extremes: saturation at full gain, silence at zero gain
   task automatic test_gain_extremes();
      set_gain(8'd255);
      send_item(svtg_pkg::OP_WRITE, 8'h2C);
      send_item(svtg_pkg::OP_TICK, 8'h00);
      send_item(svtg_pkg::OP_TICK, 8'hFF);
      set_gain(8'd0);
      send_item(svtg_pkg::OP_TICK, 8'h55);
   endtask

   // Writes to an address past the gain register leave the gain alone
   task automatic test_unmapped_register();
      logic [31:0] rdata;
      wait_for_results();
      csr_access(1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF, rdata);
      check_gain_readback();
   endtask

   // Hold the receiver off while ticks keep coming, then pause until drained
   task automatic test_output_backpressure();
      int i;
      set_gain(8'd96);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_requests++;
      send_item(svtg_pkg::OP_WRITE, 8'h2C);
      for (i = 0; i < 40; i++)
         send_item(svtg_pkg::OP_TICK, svtg_pkg::DATA_W'($urandom_range(255)));
      wait_for_results();
   endtask

   task automatic test_random_slow_receiver();
      send_idle_pct = 6;
      recv_idle_pct = 47;
      set_gain(svtg_pkg::GAIN_RESET);
      run_random(550);
   endtask

   task automatic test_random_slow_sender();
      send_idle_pct = 47;
      recv_idle_pct = 6;
      set_gain(8'd255);
      run_random(280);
      set_gain(svtg_pkg::GAIN_W'($urandom_range(255)));
      run_random(270);
   endtask

   task automatic test_random_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_gain(8'd1);
      run_random(250);
      set_gain(svtg_pkg::GAIN_W'($urandom_range(254, 128)));
      run_random(250);
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      int stalls_served;
      int stall_left;
      stalls_served = 0;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_requests != stalls_served) begin
            stalls_served++;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Compare each accepted sample with the oldest expected one
   always @(posedge clock) begin
      logic signed [svtg_pkg::SAMPLE_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected sample %0d", rsp_bus.sample);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_bus.sample !== want) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("sample mismatch: expected %0d, got %0d", want, rsp_bus.sample);
            end
         end
      end
   end

   // Stop the run when no item moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL six_voice_tone_generator");
      $finish;
   end

   initial begin
      int v;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = svtg_pkg::OP_WRITE;
      req_bus.data      = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      error_count       = 0;
      stall_requests    = 0;
      send_idle_pct     = 0;
      recv_idle_pct     = 0;
      for (v = 0; v < svtg_pkg::VOICES; v++) tone_phase[v] = '0;
      tone_enable = '0;
      tone_pitch  = '0;
      tone_gain   = svtg_pkg::GAIN_RESET;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_voice_patterns();
      test_gain_extremes();
      test_unmapped_register();
      test_random_slow_receiver();
      test_random_slow_sender();
      test_output_backpressure();
      test_random_full_rate();

      // Drain, then give stray samples a chance to show up
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS six_voice_tone_generator");
      else
         $display("FAIL six_voice_tone_generator");
      $finish;
   end

endmodule
